// File: src/sllt_pkg.sv
// ============================================================================
// sllt_pkg
// Shared types, constants and the control program of the sorted list table.
// ============================================================================
`default_nettype none

package sllt_pkg;

   localparam int ENTRIES_DEF = 64;
   localparam int KEY_W       = 32;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int PC_W        = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SEARCH,
      ACT_INSERT,
      ACT_DELETE,
      ACT_CLEAR
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_NOT_FOUND,
      ST_DUPLICATE,
      ST_FULL
   } status_type;

   // datapath operations, one per control word
   typedef enum logic [3:0] {
      DP_NOP,
      DP_HEAD,     // start a walk at the list head
      DP_WALK,     // step to the next slot while its key is below the item key
      DP_RD_FREE,  // read the link of the free head
      DP_INS_A,    // fill the fresh slot, pop the free list
      DP_INS_B,    // link the fresh slot behind prev
      DP_DEL_A,    // unlink the hit slot
      DP_DEL_B,    // push the hit slot onto the free list
      DP_FIND,
      DP_DUP,
      DP_FULL,
      DP_MISS,
      DP_CLEAR
   } dp_op_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_MORE,
      C_HIT,
      C_MISS,
      C_FULL
   } cond_type;

   typedef struct packed {
      dp_op_type        op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
      logic             last;
   } ucode_word_type;

   typedef struct packed {
      logic more;
      logic hit;
      logic full;
   } dp_flags_type;

   typedef struct packed {
      logic      exec;
      dp_op_type op;
   } dp_ctrl_type;

   // program labels
   localparam logic [PC_W-1:0] PC_SEARCH = PC_W'(0);
   localparam logic [PC_W-1:0] PC_S_WALK = PC_W'(1);
   localparam logic [PC_W-1:0] PC_INSERT = PC_W'(3);
   localparam logic [PC_W-1:0] PC_I_WALK = PC_W'(4);
   localparam logic [PC_W-1:0] PC_I_DUP  = PC_W'(8);
   localparam logic [PC_W-1:0] PC_I_FULL = PC_W'(9);
   localparam logic [PC_W-1:0] PC_DELETE = PC_W'(10);
   localparam logic [PC_W-1:0] PC_D_WALK = PC_W'(11);
   localparam logic [PC_W-1:0] PC_D_MISS = PC_W'(15);
   localparam logic [PC_W-1:0] PC_CLEAR  = PC_W'(16);

   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{op: DP_NOP, cond: C_NONE, target: PC_SEARCH, last: 1'b1};
      unique case (pc)
         // search
         PC_W'(0):  w = '{DP_HEAD,    C_NONE, PC_SEARCH, 1'b0};
         PC_W'(1):  w = '{DP_WALK,    C_MORE, PC_S_WALK, 1'b0};
         PC_W'(2):  w = '{DP_FIND,    C_NONE, PC_SEARCH, 1'b1};
         // insert
         PC_W'(3):  w = '{DP_HEAD,    C_FULL, PC_I_FULL, 1'b0};
         PC_W'(4):  w = '{DP_WALK,    C_MORE, PC_I_WALK, 1'b0};
         PC_W'(5):  w = '{DP_RD_FREE, C_HIT,  PC_I_DUP,  1'b0};
         PC_W'(6):  w = '{DP_INS_A,   C_NONE, PC_SEARCH, 1'b0};
         PC_W'(7):  w = '{DP_INS_B,   C_NONE, PC_SEARCH, 1'b1};
         PC_W'(8):  w = '{DP_DUP,     C_NONE, PC_SEARCH, 1'b1};
         PC_W'(9):  w = '{DP_FULL,    C_NONE, PC_SEARCH, 1'b1};
         // delete
         PC_W'(10): w = '{DP_HEAD,    C_NONE, PC_SEARCH, 1'b0};
         PC_W'(11): w = '{DP_WALK,    C_MORE, PC_D_WALK, 1'b0};
         PC_W'(12): w = '{DP_NOP,     C_MISS, PC_D_MISS, 1'b0};
         PC_W'(13): w = '{DP_DEL_A,   C_NONE, PC_SEARCH, 1'b0};
         PC_W'(14): w = '{DP_DEL_B,   C_NONE, PC_SEARCH, 1'b1};
         PC_W'(15): w = '{DP_MISS,    C_NONE, PC_SEARCH, 1'b1};
         // clear
         PC_W'(16): w = '{DP_CLEAR,   C_NONE, PC_SEARCH, 1'b1};
         default:   w = '{DP_NOP,     C_NONE, PC_SEARCH, 1'b1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: src/sllt_req_if.sv
// ============================================================================
// sllt_req_if
// Request channel: action and key under a valid/ready handshake.
// ============================================================================
`default_nettype none

interface sllt_req_if import sllt_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [ACTION_W-1:0]      action;
   logic signed [KEY_W-1:0]  key;

   modport source (output valid, output action, output key, input ready);
   modport sink   (input valid, input action, input key, output ready);
endinterface

`default_nettype wire

// File: src/sllt_rsp_if.sv
// ============================================================================
// sllt_rsp_if
// Response channel: status, slot and element count under valid/ready.
// ============================================================================
`default_nettype none

interface sllt_rsp_if import sllt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
);
   localparam int SLOT_W  = $clog2(ENTRIES);
   localparam int COUNT_W = $clog2(ENTRIES + 1);

   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [SLOT_W-1:0]    slot;
   logic [COUNT_W-1:0]   count;

   modport source (output valid, output status, output slot, output count, input ready);
   modport sink   (input valid, input status, input slot, input count, output ready);
endinterface

`default_nettype wire

// File: src/sllt_seq.sv
// ============================================================================
// sllt_seq
// Step counter, control store lookup and conditional branching.
// ============================================================================
`default_nettype none

module sllt_seq import sllt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [ACTION_W-1:0]  req_action,
   output logic                 req_ready,
   input  logic                 out_free,
   input  dp_flags_type         flags,
   output dp_ctrl_type          ctrl,
   output logic                 done
);

   logic             busy_ff, busy_in;
   logic [PC_W-1:0]  pc_ff, pc_in;
   ucode_word_type   word;
   logic             exec;
   logic             taken;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_SEARCH;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   always_comb begin
      word = ucode_rom(pc_ff);
      // last step waits for the output register
      exec = busy_ff && (!word.last || out_free);

      unique case (word.cond)
         C_NONE:  taken = 1'b0;
         C_MORE:  taken = flags.more;
         C_HIT:   taken = flags.hit;
         C_MISS:  taken = !flags.hit;
         C_FULL:  taken = flags.full;
         default: taken = 1'b0;
      endcase

      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (req_valid) begin
            busy_in = 1'b1;
            unique case (action_type'(req_action))
               ACT_SEARCH: pc_in = PC_SEARCH;
               ACT_INSERT: pc_in = PC_INSERT;
               ACT_DELETE: pc_in = PC_DELETE;
               ACT_CLEAR:  pc_in = PC_CLEAR;
               default:    pc_in = PC_CLEAR;
            endcase
         end
      end else if (exec) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else if (taken) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end

      req_ready = !busy_ff;
      ctrl      = '{exec: exec, op: word.op};
      done      = exec && word.last;
   end

   // a busy sequencer only stalls on a final step
   a_stall_last: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !exec) |-> word.last)
      else $error("sequencer stalled on a non-final step");

endmodule

`default_nettype wire

// File: src/sllt_dp.sv
// ============================================================================
// sllt_dp
// Datapath: key and link memories, list and free-list registers, result.
// ============================================================================
`default_nettype none

module sllt_dp import sllt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic signed [KEY_W-1:0]             req_key,
   input  dp_ctrl_type                         ctrl,
   output dp_flags_type                        flags,
   output status_type                          res_status,
   output logic [$clog2(ENTRIES)-1:0]          res_slot,
   output logic [$clog2(ENTRIES+1)-1:0]        res_count
);

   localparam int SLOT_W  = $clog2(ENTRIES);
   localparam int LINK_W  = $clog2(ENTRIES + 1);
   localparam int COUNT_W = LINK_W;
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(ENTRIES);

   // storage
   logic [KEY_W-1:0]   key_mem  [ENTRIES];
   logic [LINK_W-1:0]  link_mem [ENTRIES];

   // control state
   logic [LINK_W-1:0]   list_head_ff, list_head_in;
   logic [LINK_W-1:0]   free_head_ff, free_head_in;
   logic [LINK_W-1:0]   hwm_ff, hwm_in;        // slots at or above never had a link written
   logic [COUNT_W-1:0]  count_ff, count_in;

   // work registers
   logic signed [KEY_W-1:0]  key_ff;
   logic [LINK_W-1:0]        cur_ff, cur_in;
   logic [LINK_W-1:0]        prev_ff, prev_in;
   logic [SLOT_W-1:0]        fresh_ff, fresh_in;

   // read port
   logic                      rd_en;
   logic [SLOT_W-1:0]         rd_addr;
   logic signed [KEY_W-1:0]   key_rd_ff;
   logic [LINK_W-1:0]         link_rd_ff;
   logic [SLOT_W-1:0]         rd_addr_ff;
   logic                      rd_fresh_ff;
   logic [LINK_W-1:0]         link_q;

   // write ports
   logic                 key_we;
   logic                 link_we;
   logic [SLOT_W-1:0]    link_wa;
   logic [LINK_W-1:0]    link_wd;

   logic cur_valid, key_lt, key_eq;

   always_ff @(posedge clock) begin
      if (reset) begin
         list_head_ff <= LINK_NONE;
         free_head_ff <= '0;
         hwm_ff       <= '0;
         count_ff     <= '0;
      end else begin
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         hwm_ff       <= hwm_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= req_key;
      end
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      fresh_ff <= fresh_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[free_head_ff[SLOT_W-1:0]] <= key_ff;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (rd_en) begin
         link_rd_ff  <= link_mem[rd_addr];
         rd_addr_ff  <= rd_addr;
         rd_fresh_ff <= (LINK_W'(rd_addr) >= hwm_ff);
      end
   end

   always_comb begin
      // an unwritten link still holds its reset chain: i links to i+1
      link_q = rd_fresh_ff ? (LINK_W'(rd_addr_ff) + LINK_W'(1)) : link_rd_ff;

      cur_valid = (cur_ff < LINK_NONE);
      key_lt    = (key_rd_ff < key_ff);
      key_eq    = (key_rd_ff == key_ff);
      flags.more = cur_valid && key_lt;
      flags.hit  = cur_valid && key_eq;
      flags.full = !(free_head_ff < LINK_NONE);

      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      hwm_in       = hwm_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      fresh_in     = fresh_ff;
      rd_en        = 1'b0;
      rd_addr      = cur_ff[SLOT_W-1:0];
      key_we       = 1'b0;
      link_we      = 1'b0;
      link_wa      = prev_ff[SLOT_W-1:0];
      link_wd      = link_q;
      res_status   = ST_OK;
      res_slot     = '0;
      res_count    = count_ff;

      if (ctrl.exec) begin
         unique case (ctrl.op)
            DP_HEAD: begin
               cur_in  = list_head_ff;
               prev_in = LINK_NONE;
               rd_en   = (list_head_ff < LINK_NONE);
               rd_addr = list_head_ff[SLOT_W-1:0];
            end
            DP_WALK: begin
               if (flags.more) begin
                  prev_in = cur_ff;
                  cur_in  = link_q;
                  rd_en   = (link_q < LINK_NONE);
                  rd_addr = link_q[SLOT_W-1:0];
               end
            end
            DP_RD_FREE: begin
               rd_en   = !flags.full;
               rd_addr = free_head_ff[SLOT_W-1:0];
            end
            DP_INS_A: begin
               key_we       = 1'b1;
               link_we      = 1'b1;
               link_wa      = free_head_ff[SLOT_W-1:0];
               link_wd      = cur_ff;
               free_head_in = link_q;
               fresh_in     = free_head_ff[SLOT_W-1:0];
               if (free_head_ff == hwm_ff) begin
                  hwm_in = hwm_ff + LINK_W'(1);
               end
            end
            DP_INS_B: begin
               if (prev_ff < LINK_NONE) begin
                  link_we = 1'b1;
                  link_wa = prev_ff[SLOT_W-1:0];
                  link_wd = LINK_W'(fresh_ff);
               end else begin
                  list_head_in = LINK_W'(fresh_ff);
               end
               count_in  = count_ff + COUNT_W'(1);
               res_slot  = fresh_ff;
               res_count = count_in;
            end
            DP_DEL_A: begin
               if (prev_ff < LINK_NONE) begin
                  link_we = 1'b1;
                  link_wa = prev_ff[SLOT_W-1:0];
                  link_wd = link_q;
               end else begin
                  list_head_in = link_q;
               end
            end
            DP_DEL_B: begin
               link_we      = 1'b1;
               link_wa      = cur_ff[SLOT_W-1:0];
               link_wd      = free_head_ff;
               free_head_in = cur_ff;
               if (count_ff != '0) begin
                  count_in = count_ff - COUNT_W'(1);
               end
               res_slot  = cur_ff[SLOT_W-1:0];
               res_count = count_in;
            end
            DP_FIND: begin
               res_status = flags.hit ? ST_OK : ST_NOT_FOUND;
               res_slot   = flags.hit ? cur_ff[SLOT_W-1:0] : '0;
            end
            DP_DUP:  res_status = ST_DUPLICATE;
            DP_FULL: res_status = ST_FULL;
            DP_MISS: res_status = ST_NOT_FOUND;
            DP_CLEAR: begin
               list_head_in = LINK_NONE;
               free_head_in = '0;
               hwm_in       = '0;
               count_in     = '0;
               res_count    = '0;
            end
            default: ;
         endcase
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(ENTRIES))
      else $error("element count above table size");

   // a delete unlinks one step before the count drops
   a_empty_list: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (list_head_ff == LINK_NONE))
      else $error("empty count with a live list head");

   // an insert pops the free list one step before the count rises
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == COUNT_W'(ENTRIES)) |-> flags.full)
      else $error("table full while free list holds a slot");

endmodule

`default_nettype wire

// File: src/sorted_linked_list_table_top.sv
// ============================================================================
// sorted_linked_list_table_top
// Sorted singly linked list of signed keys in a slot table, with free list.
// ============================================================================
//
//  channel   dir  handshake      payload
//  req_ch    in   valid/ready    action[1:0], key[31:0] signed
//  rsp_ch    out  valid/ready    status[1:0], slot[SLOT_W-1:0], count[COUNT_W-1:0]
//
//  Operation: one item at a time. Search, insert and delete first walk the
//  list past the n keys below the item key, one list slot per cycle through
//  the single read port of the key and link memories; clear needs no walk.
//  Reset: synchronous; empties the list and chains all slots into the free
//  list at once (unwritten links read as their reset chain), no sweep.
//  Stalls: the response register holds one finished result; the next request
//  is taken meanwhile and its program waits only at its final step.
//
`default_nettype none

module sorted_linked_list_table_top import sllt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   sllt_req_if.sink     req_ch,
   sllt_rsp_if.source   rsp_ch
);

   localparam int SLOT_W  = $clog2(ENTRIES);
   localparam int COUNT_W = $clog2(ENTRIES + 1);

   logic          req_ready;
   logic          accept;
   logic          out_free;
   logic          done;
   dp_ctrl_type   ctrl;
   dp_flags_type  flags;

   status_type            res_status;
   logic [SLOT_W-1:0]     res_slot;
   logic [COUNT_W-1:0]    res_count;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   assign accept       = req_ch.valid && req_ready;
   assign req_ch.ready = req_ready;

   // the final step may load the register when it is empty or draining
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   sllt_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ready),
      .out_free   (out_free),
      .flags      (flags),
      .ctrl       (ctrl),
      .done       (done)
   );

   sllt_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_key    (req_ch.key),
      .ctrl       (ctrl),
      .flags      (flags),
      .res_status (res_status),
      .res_slot   (res_slot),
      .res_count  (res_count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_status_ff <= res_status;
         rsp_slot_ff   <= res_slot;
         rsp_count_ff  <= res_count;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.slot   = rsp_slot_ff;
   assign rsp_ch.count  = rsp_count_ff;

   // a transfer starts a program, so the request side closes right after
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request taken while a program runs");

   // every finished program shows up on the response side
   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule

`default_nettype wire

// File: tb/sv/sllt_tb_pkg.sv
// ============================================================================
// sllt_tb_pkg
// Scoreboard for the sorted list table: shadow table, awaited results, checks.
// ============================================================================
`default_nettype none

package sllt_tb_pkg;
   import sllt_pkg::*;

   localparam int TABLE_SLOTS = 64;
   localparam int SLOT_W      = $clog2(TABLE_SLOTS);
   localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);
   localparam int LINK_W      = $clog2(TABLE_SLOTS) + 1;

   // link value one past the last slot marks the end of a chain
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(TABLE_SLOTS);

   class table_scoreboard;
      typedef struct packed {
         status_type          status;
         logic [SLOT_W-1:0]   slot;
         logic [COUNT_W-1:0]  count;
      } table_result_type;

      logic signed [KEY_W-1:0] key_mem  [TABLE_SLOTS];
      logic [LINK_W-1:0]       link_mem [TABLE_SLOTS];
      logic [LINK_W-1:0]       list_head;
      logic [LINK_W-1:0]       free_head;
      logic [COUNT_W-1:0]      keys_held;
      table_result_type        awaited_results[$];
      int unsigned             failures;
      int unsigned             responses;
      int unsigned             action_seen[4];
      int unsigned             status_seen[4];
      int unsigned             peak_fill;

      function new();
         empty_table();
      endfunction

      // every slot chained into the free list, last one ends the chain
      function void empty_table();
         for (int i = 0; i < TABLE_SLOTS; i++)
            link_mem[i] = LINK_W'(i + 1);
         list_head = LINK_NONE;
         free_head = '0;
         keys_held = '0;
      endfunction

      // first slot whose key is not below k; prev is the slot just before it
      function logic [LINK_W-1:0] find_place(input logic signed [KEY_W-1:0] k,
                                             output logic [LINK_W-1:0] prev);
         logic [LINK_W-1:0] cur;
         int unsigned       hops;
         cur  = list_head;
         prev = LINK_NONE;
         hops = 0;
         while (cur != LINK_NONE && hops < TABLE_SLOTS && key_mem[cur] < k) begin
            prev = cur;
            cur  = link_mem[cur];
            hops++;
         end
         return (hops >= TABLE_SLOTS) ? LINK_NONE : cur;
      endfunction

      function void note_request(input action_type act, input logic signed [KEY_W-1:0] k);
         table_result_type   res;
         logic [LINK_W-1:0]  prev;
         logic [LINK_W-1:0]  at;
         logic [LINK_W-1:0]  fresh;
         res = '{status: ST_OK, slot: '0, count: '0};
         at  = find_place(k, prev);
         case (act)
            ACT_SEARCH: begin
               if (at != LINK_NONE && key_mem[at] == k)
                  res.slot = at[SLOT_W-1:0];
               else
                  res.status = ST_NOT_FOUND;
            end
            ACT_INSERT: begin
               // full is reported ahead of duplicate
               if (free_head == LINK_NONE) begin
                  res.status = ST_FULL;
               end else if (at != LINK_NONE && key_mem[at] == k) begin
                  res.status = ST_DUPLICATE;
               end else begin
                  fresh          = free_head;
                  free_head      = link_mem[fresh];
                  key_mem[fresh] = k;
                  if (prev == LINK_NONE) begin
                     link_mem[fresh] = list_head;
                     list_head       = fresh;
                  end else begin
                     link_mem[fresh] = link_mem[prev];
                     link_mem[prev]  = fresh;
                  end
                  keys_held++;
                  res.slot = fresh[SLOT_W-1:0];
               end
            end
            ACT_DELETE: begin
               if (at == LINK_NONE || key_mem[at] != k) begin
                  res.status = ST_NOT_FOUND;
               end else begin
                  if (prev == LINK_NONE)
                     list_head = link_mem[at];
                  else
                     link_mem[prev] = link_mem[at];
                  link_mem[at] = free_head;
                  free_head    = at;
                  keys_held--;
                  res.slot = at[SLOT_W-1:0];
               end
            end
            ACT_CLEAR: empty_table();
         endcase
         res.count = keys_held;
         action_seen[act]++;
         status_seen[res.status]++;
         if (keys_held > peak_fill)
            peak_fill = keys_held;
         awaited_results.push_back(res);
      endfunction

      function void check_response(input logic [STATUS_W-1:0] st,
                                   input logic [SLOT_W-1:0]   sl,
                                   input logic [COUNT_W-1:0]  ct);
         table_result_type want;
         responses++;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 20)
               $display("%0t: response with nothing awaited: status %0d slot %0d count %0d",
                        $time, st, sl, ct);
            return;
         end
         want = awaited_results.pop_front();
         if (st !== want.status || sl !== want.slot || ct !== want.count) begin
            failures++;
            if (failures <= 20)
               $display("%0t: rsp %0d expected %0d/%0d/%0d got %0d/%0d/%0d (status/slot/count)",
                        $time, responses, want.status, want.slot, want.count, st, sl, ct);
         end
      endfunction

      function int unsigned pending();
         return awaited_results.size();
      endfunction
   endclass

endpackage

`default_nettype wire

// File: tb/sv/testbench.sv
// ============================================================================
// testbench
// Drives the sorted list table with directed and random actions and checks
// every response against a shadow copy of the table kept by the scoreboard.
// ============================================================================
`default_nettype none

module testbench import sllt_pkg::*, sllt_tb_pkg::*;;

   localparam int ITEMS       = 1400;
   localparam int CALM_ITEMS  = 150;     // tail of the run with no idling
   localparam int HOLD_CYCLES = 400;     // long receiver hold-off
   localparam int CYCLE_LIMIT = 800_000;
   localparam int POOL_SIZE   = 96;      // above the slot count so mixed traffic can fill up

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef enum {SEG_MIXED, SEG_FILL, SEG_DRAIN, SEG_CLEAR} segment_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sllt_req_if                          req_ch ();
   sllt_rsp_if #(.ENTRIES(TABLE_SLOTS)) rsp_ch ();

   sorted_linked_list_table_top #(.ENTRIES(TABLE_SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   table_scoreboard          book;
   logic signed [KEY_W-1:0]  key_pool [POOL_SIZE];
   logic signed [KEY_W-1:0]  live_keys[$];   // keys sent for insert, likely still stored
   int unsigned              sent;
   int unsigned              idle_pct;
   bit                       calm;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every transfer on the response side goes to the scoreboard. Sampled at the
   // rising edge, so the block's own updates at this edge are not yet visible.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         book.check_response(rsp_ch.status, rsp_ch.slot, rsp_ch.count);
   end

   function automatic logic signed [KEY_W-1:0] pick_live();
      if (live_keys.size() == 0)
         return $urandom();
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
   endfunction

   // One request transfer. Called at a falling edge, returns at a falling edge.
   // Valid stays high from one transfer to the next unless a gap is inserted,
   // so it is never lowered and raised within one time step.
   task automatic send_request(input action_type act, input logic signed [KEY_W-1:0] k);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.key    <= k;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      book.note_request(act, k);
      if (act == ACT_INSERT) begin
         live_keys.push_back(k);
         if (live_keys.size() > 160)
            void'(live_keys.pop_front());
      end else if (act == ACT_CLEAR) begin
         live_keys.delete();
      end
      sent++;
      calm = (sent >= ITEMS - CALM_ITEMS);
      @(negedge clock);
   endtask

   // Fill the table to the last slot with random keys, keep pushing so the
   // full status shows up (once with a key that is already stored), then
   // look a few keys up in the packed table.
   task automatic fill_table();
      int unsigned extra;
      extra = $urandom_range(1, 4);
      repeat (TABLE_SLOTS + extra)
         send_request(ACT_INSERT, $urandom());
      send_request(ACT_INSERT, pick_live());
      repeat (4)
         send_request(ACT_SEARCH, pick_live());
   endtask

   // ---------------------------------------------------------------------------
   // Request side: reset, directed actions, then random segments.
   // ---------------------------------------------------------------------------
   initial begin : request_source
      logic signed [KEY_W-1:0] k;
      action_type              act;
      segment_kind_type        seg;
      int unsigned             r;
      int unsigned             n;
      int unsigned             idx;

      book          = new();
      req_ch.valid  = 1'b0;
      req_ch.action = ACT_SEARCH;
      req_ch.key    = '0;
      idle_pct      = 25;

      // pool: extremes, a band of small keys, and keys from the full range
      key_pool[0] = KEY_MIN;
      key_pool[1] = KEY_MIN + 1;
      key_pool[2] = -1;
      key_pool[3] = 0;
      key_pool[4] = 1;
      key_pool[5] = KEY_MAX - 1;
      key_pool[6] = KEY_MAX;
      for (int i = 7; i < POOL_SIZE; i++) begin
         if (i < 52)
            key_pool[i] = $signed($urandom_range(0, 200)) - 100;
         else
            key_pool[i] = $urandom();
      end

      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_request(ACT_SEARCH, 0);              // search on the empty list
      send_request(ACT_DELETE, -1);             // delete from the empty list
      send_request(ACT_INSERT, 0);
      send_request(ACT_INSERT, KEY_MIN);        // new head
      send_request(ACT_INSERT, KEY_MAX);        // new tail
      send_request(ACT_INSERT, -1);             // between head and middle
      send_request(ACT_INSERT, 1);
      send_request(ACT_INSERT, 0);              // duplicate
      send_request(ACT_SEARCH, KEY_MIN);
      send_request(ACT_SEARCH, KEY_MAX);
      send_request(ACT_SEARCH, 5);              // absent
      send_request(ACT_SEARCH, 32'sh5555_5555); // absent, above the middle
      send_request(ACT_DELETE, 0);              // from the middle
      send_request(ACT_DELETE, KEY_MIN);        // the head
      send_request(ACT_DELETE, KEY_MAX);        // the tail
      send_request(ACT_DELETE, 0);              // already gone
      send_request(ACT_INSERT, 32'shAAAA_AAAA); // reuses a freed slot
      send_request(ACT_INSERT, 32'sh5555_5555);
      send_request(ACT_CLEAR, -1);              // key ignored
      send_request(ACT_SEARCH, -1);
      send_request(ACT_DELETE, 1);
      send_request(ACT_INSERT, -1);             // slot zero again after clear
      send_request(ACT_CLEAR, 0);

      // --- random part: full table first, then random segments ---
      fill_table();
      while (sent < ITEMS) begin
         idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
         r = $urandom_range(0, 99);
         seg = (r < 55) ? SEG_MIXED : (r < 70) ? SEG_FILL : (r < 90) ? SEG_DRAIN : SEG_CLEAR;
         case (seg)
            SEG_MIXED: begin
               repeat ($urandom_range(20, 60)) begin
                  r = $urandom_range(0, 99);
                  k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                  if ($urandom_range(0, 3) == 0)
                     k = $urandom();
                  if (r >= 45 && live_keys.size() != 0 && $urandom_range(0, 9) < 7)
                     k = pick_live();
                  act = (r < 45) ? ACT_INSERT : (r < 72) ? ACT_DELETE :
                        (r < 98) ? ACT_SEARCH : ACT_CLEAR;
                  send_request(act, k);
               end
            end
            SEG_FILL: fill_table();
            SEG_DRAIN: begin
               // delete keys likely still stored, in random order, down toward empty
               n = $urandom_range(16, 72);
               for (int i = 0; i < n && live_keys.size() != 0; i++) begin
                  idx = $urandom_range(0, live_keys.size() - 1);
                  k   = live_keys[idx];
                  live_keys.delete(idx);
                  send_request(ACT_DELETE, k);
               end
            end
            SEG_CLEAR: send_request(ACT_CLEAR, $urandom());
         endcase
      end

      // --- wind-down: all responses in, then a walk's worth of quiet cycles ---
      req_ch.valid <= 1'b0;
      while (book.pending() != 0)
         @(negedge clock);
      repeat (TABLE_SLOTS + 16) @(negedge clock);

      $display("covered %0d transfers: %0d search, %0d insert, %0d delete, %0d clear",
               sent, book.action_seen[ACT_SEARCH], book.action_seen[ACT_INSERT],
               book.action_seen[ACT_DELETE], book.action_seen[ACT_CLEAR]);
      $display("%0d responses: ok %0d, not found %0d, duplicate %0d, full %0d, peak fill %0d",
               book.responses, book.status_seen[ST_OK], book.status_seen[ST_NOT_FOUND],
               book.status_seen[ST_DUPLICATE], book.status_seen[ST_FULL],
               book.peak_fill);
      if (book.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Response side: ready with random stall bursts. Once, early on, it holds
   // off for a long stretch so the block backs up and stops taking requests.
   // ---------------------------------------------------------------------------
   initial begin : response_sink
      int unsigned stall_left;
      int unsigned stall_pct;
      int unsigned mood_left;
      bit          held_off;

      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      stall_pct    = 12;
      mood_left    = 0;
      held_off     = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (mood_left == 0) begin
            // stretches with no stalls at all, and stretches with bursts
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
            mood_left = $urandom_range(50, 300);
         end else begin
            mood_left--;
         end
         if (!held_off && book.responses >= 60) begin
            held_off   = 1'b1;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 19);
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      #(CYCLE_LIMIT * 10);
      $display("%0t: timeout with %0d responses still awaited", $time, book.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
